// ----- hw/rtl/mafh_pkg.sv -----
// ----------------------------------------------------------------------------
// mafh_pkg
// shared types, header field codes and frame length tables for the
// layer iii frame header decode unit
// ----------------------------------------------------------------------------
package mafh_pkg;

    // header field positions
    localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

    // version id codes as they appear in header bits 20..19
    localparam logic [1:0] ID_MPEG25   = 2'b00;
    localparam logic [1:0] ID_RESERVED = 2'b01;
    localparam logic [1:0] ID_MPEG2    = 2'b10;
    localparam logic [1:0] ID_MPEG1    = 2'b11;

    // decoded version codes
    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    // layer code for layer iii
    localparam logic [1:0] LAYER_III = 2'b01;

    // bitrate and sample rate index codes that are rejected
    localparam logic [3:0] BR_FREE     = 4'd0;
    localparam logic [3:0] BR_BAD      = 4'd15;
    localparam logic [1:0] SR_RESERVED = 2'd3;

    // sample rate index codes
    localparam logic [1:0] SR_IDX0 = 2'd0;
    localparam logic [1:0] SR_IDX1 = 2'd1;
    localparam logic [1:0] SR_IDX2 = 2'd2;

    // channel modes
    localparam logic [1:0] MODE_STEREO = 2'd0;
    localparam logic [1:0] MODE_JOINT  = 2'd1;
    localparam logic [1:0] MODE_DUAL   = 2'd2;
    localparam logic [1:0] MODE_MONO   = 2'd3;

    // side information sizes in bytes
    localparam logic [10:0] SIDE_V1_STEREO = 11'd32;
    localparam logic [10:0] SIDE_V1_MONO   = 11'd17;
    localparam logic [10:0] SIDE_V2_STEREO = 11'd17;
    localparam logic [10:0] SIDE_V2_MONO   = 11'd9;
    localparam logic [10:0] HEADER_BYTES   = 11'd4;
    localparam logic [10:0] CRC_LEN        = 11'd2;

    // bitrate tables in kbps
    localparam logic [8:0] KBPS_V1 [16] = '{
        9'd0,   9'd32,  9'd40,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [8:0] KBPS_V2 [16] = '{
        9'd0,   9'd8,   9'd16,  9'd24,  9'd32,  9'd40,  9'd48,  9'd56,
        9'd64,  9'd80,  9'd96,  9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };

    // frame lengths for the 44.1 khz family, the only rates that do not divide evenly
    // mpeg-1 at 44100: 144000 * kbps / 44100 = kbps * 1440 / 441
    localparam logic [10:0] LEN_V1_44K [16] = '{
        11'(0),            11'(32 * 1440 / 441),  11'(40 * 1440 / 441),
        11'(48 * 1440 / 441),  11'(56 * 1440 / 441),  11'(64 * 1440 / 441),
        11'(80 * 1440 / 441),  11'(96 * 1440 / 441),  11'(112 * 1440 / 441),
        11'(128 * 1440 / 441), 11'(160 * 1440 / 441), 11'(192 * 1440 / 441),
        11'(224 * 1440 / 441), 11'(256 * 1440 / 441), 11'(320 * 1440 / 441),
        11'(0)
    };
    // mpeg-2 at 22050: 72000 * kbps / 22050 = kbps * 1440 / 441
    localparam logic [10:0] LEN_V2_22K [16] = '{
        11'(0),            11'(8 * 1440 / 441),   11'(16 * 1440 / 441),
        11'(24 * 1440 / 441),  11'(32 * 1440 / 441),  11'(40 * 1440 / 441),
        11'(48 * 1440 / 441),  11'(56 * 1440 / 441),  11'(64 * 1440 / 441),
        11'(80 * 1440 / 441),  11'(96 * 1440 / 441),  11'(112 * 1440 / 441),
        11'(128 * 1440 / 441), 11'(144 * 1440 / 441), 11'(160 * 1440 / 441),
        11'(0)
    };
    // mpeg-2.5 at 11025: 72000 * kbps / 11025 = kbps * 2880 / 441
    localparam logic [10:0] LEN_V25_11K [16] = '{
        11'(0),            11'(8 * 2880 / 441),   11'(16 * 2880 / 441),
        11'(24 * 2880 / 441),  11'(32 * 2880 / 441),  11'(40 * 2880 / 441),
        11'(48 * 2880 / 441),  11'(56 * 2880 / 441),  11'(64 * 2880 / 441),
        11'(80 * 2880 / 441),  11'(96 * 2880 / 441),  11'(112 * 2880 / 441),
        11'(128 * 2880 / 441), 11'(144 * 2880 / 441), 11'(160 * 2880 / 441),
        11'(0)
    };

    // one decoded header
    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version;
        logic        has_crc;
        logic [8:0]  kbit_rate;
        logic [15:0] sample_rate_hz;
        logic        padding;
        logic [1:0]  stereo_mode;
        logic [1:0]  joint_flags;
        logic [2:0]  misc_flags;
        logic [1:0]  emphasis;
        logic [10:0] frame_bytes;
        logic [10:0] main_data_bytes;
    } t_result;

endpackage

// ----- hw/rtl/mafh_decode.sv -----
// ----------------------------------------------------------------------------
// mafh_decode
// combinational decode of one frame header word into its fields and lengths
// ----------------------------------------------------------------------------
module mafh_decode (
    input  logic [31:0]      i_word,
    output mafh_pkg::t_result o_res
);

    logic        sync_ok;
    logic        ver_ok;
    logic        fields_ok;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [3:0]  br_idx;
    logic [1:0]  sr_idx;
    logic [1:0]  mode;
    logic        crc;
    logic        pad;
    logic [8:0]  kbps;
    logic [15:0] rate;
    logic [11:0] kb12;
    logic [11:0] k3;
    logic [11:0] k6;
    logic [11:0] k9;
    logic [11:0] k45;
    logic [10:0] base_len;
    logic [10:0] fbytes;
    logic [10:0] side;
    logic [10:0] crc_len;
    logic [10:0] mbytes;
    mafh_pkg::t_result full;

    assign layer  = i_word[18:17];
    assign br_idx = i_word[15:12];
    assign sr_idx = i_word[11:10];
    assign mode   = i_word[7:6];
    assign crc    = ~i_word[16];
    assign pad    = i_word[9];

    assign sync_ok   = (i_word & mafh_pkg::SYNC_MASK) == mafh_pkg::SYNC_MASK;
    assign fields_ok = (layer == mafh_pkg::LAYER_III) && (br_idx != mafh_pkg::BR_FREE)
                    && (br_idx != mafh_pkg::BR_BAD) && (sr_idx != mafh_pkg::SR_RESERVED);

    always_comb begin
        ver_ok = 1'b1;
        unique case (i_word[20:19])
            mafh_pkg::ID_MPEG1:  ver = mafh_pkg::VER_MPEG1;
            mafh_pkg::ID_MPEG2:  ver = mafh_pkg::VER_MPEG2;
            mafh_pkg::ID_MPEG25: ver = mafh_pkg::VER_MPEG25;
            default: begin
                ver    = mafh_pkg::VER_MPEG1;
                ver_ok = 1'b0;
            end
        endcase
    end

    assign kbps = (ver == mafh_pkg::VER_MPEG1) ? mafh_pkg::KBPS_V1[br_idx]
                                               : mafh_pkg::KBPS_V2[br_idx];

    // small multiples of kbps for the rates that divide evenly
    assign kb12 = {3'b000, kbps};
    assign k3   = (kb12 << 1) + kb12;
    assign k6   = k3 << 1;
    assign k9   = (kb12 << 3) + kb12;
    assign k45  = k9 >> 1;

    always_comb begin
        rate     = 16'd0;
        base_len = 11'd0;
        unique case ({ver, sr_idx})
            {mafh_pkg::VER_MPEG1, mafh_pkg::SR_IDX0}: begin
                rate     = 16'd44100;
                base_len = mafh_pkg::LEN_V1_44K[br_idx];
            end
            {mafh_pkg::VER_MPEG1, mafh_pkg::SR_IDX1}: begin
                rate     = 16'd48000;
                base_len = k3[10:0];
            end
            {mafh_pkg::VER_MPEG1, mafh_pkg::SR_IDX2}: begin
                rate     = 16'd32000;
                base_len = k45[10:0];
            end
            {mafh_pkg::VER_MPEG2, mafh_pkg::SR_IDX0}: begin
                rate     = 16'd22050;
                base_len = mafh_pkg::LEN_V2_22K[br_idx];
            end
            {mafh_pkg::VER_MPEG2, mafh_pkg::SR_IDX1}: begin
                rate     = 16'd24000;
                base_len = k3[10:0];
            end
            {mafh_pkg::VER_MPEG2, mafh_pkg::SR_IDX2}: begin
                rate     = 16'd16000;
                base_len = k45[10:0];
            end
            {mafh_pkg::VER_MPEG25, mafh_pkg::SR_IDX0}: begin
                rate     = 16'd11025;
                base_len = mafh_pkg::LEN_V25_11K[br_idx];
            end
            {mafh_pkg::VER_MPEG25, mafh_pkg::SR_IDX1}: begin
                rate     = 16'd12000;
                base_len = k6[10:0];
            end
            {mafh_pkg::VER_MPEG25, mafh_pkg::SR_IDX2}: begin
                rate     = 16'd8000;
                base_len = k9[10:0];
            end
            default: begin
                rate     = 16'd0;
                base_len = 11'd0;
            end
        endcase
    end

    assign fbytes = base_len + {10'd0, pad};

    always_comb begin
        if (ver == mafh_pkg::VER_MPEG1) begin
            side = (mode == mafh_pkg::MODE_MONO) ? mafh_pkg::SIDE_V1_MONO
                                                 : mafh_pkg::SIDE_V1_STEREO;
        end else begin
            side = (mode == mafh_pkg::MODE_MONO) ? mafh_pkg::SIDE_V2_MONO
                                                 : mafh_pkg::SIDE_V2_STEREO;
        end
    end

    assign crc_len = crc ? mafh_pkg::CRC_LEN : 11'd0;
    assign mbytes  = fbytes - mafh_pkg::HEADER_BYTES - side - crc_len;

    always_comb begin
        full.valid_res       = 1'b1;
        full.version         = ver;
        full.has_crc         = crc;
        full.kbit_rate       = kbps;
        full.sample_rate_hz  = rate;
        full.padding         = pad;
        full.stereo_mode     = mode;
        full.joint_flags     = (mode == mafh_pkg::MODE_JOINT) ? i_word[5:4] : 2'b00;
        full.misc_flags      = {i_word[8], i_word[3], i_word[2]};
        full.emphasis        = i_word[1:0];
        full.frame_bytes     = fbytes;
        full.main_data_bytes = mbytes;
    end

    // rejected headers give an all-zero result
    assign o_res = (sync_ok && ver_ok && fields_ok) ? full : '0;

endmodule

// ----- hw/rtl/mpeg_audio_frame_header_decode_unit.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decode_unit
// pipeline: a header word taken at a clock edge is held in the input register, passes
//   the decode logic and is loaded into the result register, where o_done marks it
// throughput: one header word per cycle, busy never rises, the receiver cannot stall
// reset: synchronous active-low i_rst_n clears both valid flags, payload is not reset
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_decode_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_header_word,
    // result channel, one cycle strobe
    output logic        o_done,
    output logic        o_valid_res,
    output logic [1:0]  o_version,
    output logic        o_has_crc,
    output logic [8:0]  o_kbit_rate,
    output logic [15:0] o_sample_rate_hz,
    output logic        o_padding,
    output logic [1:0]  o_stereo_mode,
    output logic [1:0]  o_joint_flags,
    output logic [2:0]  o_misc_flags,
    output logic [1:0]  o_emphasis,
    output logic [10:0] o_frame_bytes,
    output logic [10:0] o_main_data_bytes
);

    // input stage
    logic              r_in_vld;
    logic              n_in_vld;
    logic [31:0]       r_word;

    // result stage
    logic              r_out_vld;
    logic              n_out_vld;
    mafh_pkg::t_result r_res;
    mafh_pkg::t_result dec_res;

    // every decode finishes in one pass, so the unit never pushes back
    assign busy = 1'b0;

    // a transaction is taken whenever start is high and busy is low
    assign n_in_vld  = start && !busy;
    assign n_out_vld = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers only load on a live transaction
    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_word <= i_header_word;
        end
        if (r_in_vld) begin
            r_res <= dec_res;
        end
    end

    // all checks, table lookups and length math sit between r_word and r_res
    mafh_decode u_decode (
        .i_word (r_word),
        .o_res  (dec_res)
    );

    // result ports, held between strobes but only meaningful while o_done is high
    assign o_done            = r_out_vld;
    assign o_valid_res       = r_res.valid_res;
    assign o_version         = r_res.version;
    assign o_has_crc         = r_res.has_crc;
    assign o_kbit_rate       = r_res.kbit_rate;
    assign o_sample_rate_hz  = r_res.sample_rate_hz;
    assign o_padding         = r_res.padding;
    assign o_stereo_mode     = r_res.stereo_mode;
    assign o_joint_flags     = r_res.joint_flags;
    assign o_misc_flags      = r_res.misc_flags;
    assign o_emphasis        = r_res.emphasis;
    assign o_frame_bytes     = r_res.frame_bytes;
    assign o_main_data_bytes = r_res.main_data_bytes;

`ifndef SYNTHESIS
    // every taken transaction produces its strobe after the input and result registers
    a_start_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing two cycles after an accepted header");

    // no strobe without a matching transaction through the input and result registers
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without a matching transaction");

    // rejected headers carry an all-zero payload
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> (o_frame_bytes == 11'd0 && o_kbit_rate == 9'd0
            && o_sample_rate_hz == 16'd0 && o_main_data_bytes == 11'd0))
        else $error("rejected header produced nonzero fields");

    // main data always fits inside the frame for a good header
    a_main_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_valid_res) |-> (o_main_data_bytes < o_frame_bytes))
        else $error("main data length not below frame length");
`endif

endmodule
